// ===== sv/zpfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfa_pkg: shared definitions of the zoned page-frame allocator
// Operation, status and register codes and the default sizes.
// ----------------------------------------------------------------------------
package zpfa_pkg;

    localparam int NUM_FRAMES_DEF = 65536;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [2:0] OP_ADD_FREE = 3'd0;
    localparam logic [2:0] OP_ALLOC    = 3'd1;
    localparam logic [2:0] OP_USE      = 3'd2;
    localparam logic [2:0] OP_FREE     = 3'd3;
    localparam logic [2:0] OP_RESERVE  = 3'd4;
    localparam logic [2:0] OP_QUERY    = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_OOM     = 3'd3;
    localparam logic [2:0] ST_REFERR  = 3'd4;

    localparam logic [1:0] ZR_NORMAL = 2'd0;
    localparam logic [1:0] ZR_DMA    = 2'd1;
    localparam logic [1:0] ZR_BIOS   = 2'd2;

    localparam logic [1:0] ZN_NORMAL = 2'd0;
    localparam logic [1:0] ZN_DMA    = 2'd1;
    localparam logic [1:0] ZN_BIOS   = 2'd2;

    localparam logic [1:0] CFG_LAST_FRAME = 2'd0;
    localparam logic [1:0] CFG_BIOS_LIMIT = 2'd1;
    localparam logic [1:0] CFG_DMA_LIMIT  = 2'd2;

    localparam logic [15:0] LAST_FRAME_RST = 16'd65535;
    localparam logic [16:0] BIOS_LIMIT_RST = 17'd256;
    localparam logic [16:0] DMA_LIMIT_RST  = 17'd4096;
    localparam logic [16:0] TOT_MAX        = 17'h1FFFF;

endpackage

// ===== sv/zpfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module zpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/zoned_page_frame_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zoned_page_frame_allocator_core: zoned page-frame allocator with refcounts
// Three LIFO doubly linked free lists (bios, dma, normal) kept in a link RAM,
// and per-frame reference count, reserved and listed bits kept in a meta RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                          Flow control
//  -------   -----------------------------------------------  ----------------
//  command   start, opcode, frame_number, zone_request        start & !busy
//  result    done, status, granted_frame, usage_count,        done, no stall
//            free_total, used_total
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data        valid & ready
//
// Beat to beat: a command rejected before any RAM access is shortest, one with no
// list change also passes S_RD and S_EVAL, and a push or an unlink adds link RAM
// states, set by the link RAM's single read and single write port that every list
// neighbor passes through. After reset the meta RAM is swept one frame per cycle
// with busy high. Configuration beats are taken at any time.
// The result beat is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module zoned_page_frame_allocator_core #(
    parameter int NUM_FRAMES = zpfa_pkg::NUM_FRAMES_DEF,
    parameter int COUNT_BITS = zpfa_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [15:0] frame_number,
    input  logic [1:0]  zone_request,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] granted_frame,
    output logic [15:0] usage_count,
    output logic [16:0] free_total,
    output logic [16:0] used_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    // Frame index width, link width (top bit marks the null link), meta width.
    localparam int FB = $clog2(NUM_FRAMES);
    localparam int LW = FB + 1;
    localparam int CW = COUNT_BITS;
    localparam int MW = CW + 2;

    localparam logic [LW-1:0] NULL_LINK = {1'b1, {FB{1'b0}}};
    localparam logic [CW-1:0] CNT_MAX   = {CW{1'b1}};
    localparam logic [FB-1:0] LAST_IDX  = FB'(NUM_FRAMES - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_EVAL,
        S_U1, S_U2, S_U3, S_U4, S_P1, S_P2, S_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [15:0] last_frame_reg;
    logic [16:0] bios_limit_reg;
    logic [16:0] dma_limit_reg;

    // Operation context.
    logic [2:0]    op_reg;
    logic [FB-1:0] tgt_reg;
    logic [LW-1:0] n_reg;
    logic [LW-1:0] p_reg;
    logic [LW-1:0] h_reg;
    logic          push_reg;
    logic          unlink_reg;
    logic [FB-1:0] clr_reg;

    logic [LW-1:0] head_reg [3];
    logic [16:0]   free_cnt_reg;
    logic [16:0]   used_cnt_reg;

    // Result registers.
    logic          done_reg;
    logic [2:0]    status_reg;
    logic [15:0]   granted_reg;
    logic [CW-1:0] usage_reg;

    // RAM ports.
    logic          m_we;
    logic [FB-1:0] m_waddr;
    logic [MW-1:0] m_wdata;
    logic          m_re;
    logic [MW-1:0] m_q;
    logic          l_we;
    logic [FB-1:0] l_waddr;
    logic [2*LW-1:0] l_wdata;
    logic          l_re;
    logic [FB-1:0] l_raddr;
    logic [2*LW-1:0] l_q;

    // Meta word: reserved bit, listed bit, reference count.
    logic [CW-1:0] m_cnt;
    logic          m_inl;
    logic          m_res;
    logic [LW-1:0] lq_next;
    logic [LW-1:0] lq_prev;

    assign m_cnt   = m_q[CW-1:0];
    assign m_inl   = m_q[CW];
    assign m_res   = m_q[CW+1];
    assign lq_next = l_q[2*LW-1:LW];
    assign lq_prev = l_q[LW-1:0];

    zpfa_ram #(.WIDTH(MW), .DEPTH(NUM_FRAMES)) u_meta_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (tgt_reg),
        .rdata (m_q)
    );

    zpfa_ram #(.WIDTH(2 * LW), .DEPTH(NUM_FRAMES)) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_q)
    );

    // Command decode at accept time: existence check and alloc zone choice.
    logic          exists;
    logic          alloc_fail;
    logic [2:0]    alloc_status;
    logic [1:0]    alloc_zone;

    assign exists = (frame_number <= last_frame_reg)
                    && ({16'b0, frame_number} < 32'(NUM_FRAMES));

    always_comb
    begin
        alloc_zone   = zpfa_pkg::ZN_NORMAL;
        alloc_fail   = 1'b0;
        alloc_status = zpfa_pkg::ST_OK;
        if (zone_request == zpfa_pkg::ZR_DMA || zone_request == zpfa_pkg::ZR_BIOS)
        begin
            alloc_zone = (zone_request == zpfa_pkg::ZR_DMA) ? zpfa_pkg::ZN_DMA
                                                            : zpfa_pkg::ZN_BIOS;
            if (head_reg[alloc_zone][LW-1])
            begin
                alloc_fail   = 1'b1;
                alloc_status = zpfa_pkg::ST_EMPTY;
            end
        end
        else if (!head_reg[zpfa_pkg::ZN_NORMAL][LW-1])
        begin
            alloc_zone = zpfa_pkg::ZN_NORMAL;
        end
        else if (!head_reg[zpfa_pkg::ZN_DMA][LW-1])
        begin
            alloc_zone = zpfa_pkg::ZN_DMA;
        end
        else if (!head_reg[zpfa_pkg::ZN_BIOS][LW-1])
        begin
            alloc_zone = zpfa_pkg::ZN_BIOS;
        end
        else
        begin
            alloc_fail   = 1'b1;
            alloc_status = zpfa_pkg::ST_OOM;
        end
    end

    // Evaluation of the read-back meta word.
    logic [2:0]    ev_status;
    logic [CW-1:0] ev_usage;
    logic [MW-1:0] ev_meta;
    logic          ev_mwe;
    logic          ev_push;
    logic          ev_unlink;
    logic          ev_free_inc;
    logic          ev_free_dec;
    logic          ev_used_inc;
    logic          ev_used_dec;
    logic [CW-1:0] cnt_dec;

    assign cnt_dec = m_cnt - CW'(1);

    always_comb
    begin
        ev_status   = zpfa_pkg::ST_OK;
        ev_usage    = m_cnt;
        ev_meta     = m_q;
        ev_mwe      = 1'b0;
        ev_push     = 1'b0;
        ev_unlink   = 1'b0;
        ev_free_inc = 1'b0;
        ev_free_dec = 1'b0;
        ev_used_inc = 1'b0;
        ev_used_dec = 1'b0;
        case (op_reg) inside
            zpfa_pkg::OP_ALLOC:
            begin
                ev_meta     = {m_res, 1'b0, CW'(1)};
                ev_mwe      = 1'b1;
                ev_unlink   = 1'b1;
                ev_free_dec = 1'b1;
                ev_used_inc = 1'b1;
                ev_usage    = CW'(1);
            end
            zpfa_pkg::OP_ADD_FREE:
            begin
                if (m_inl || m_cnt != '0)
                begin
                    ev_status = zpfa_pkg::ST_IGNORED;
                end
                else
                begin
                    ev_meta     = {1'b0, 1'b1, m_cnt};
                    ev_mwe      = 1'b1;
                    ev_push     = 1'b1;
                    ev_free_inc = 1'b1;
                end
            end
            zpfa_pkg::OP_USE, zpfa_pkg::OP_FREE:
            begin
                if (m_res)
                begin
                    ev_status = zpfa_pkg::ST_IGNORED;
                end
                else if (m_cnt == '0)
                begin
                    ev_status = zpfa_pkg::ST_REFERR;
                end
                else if (op_reg == zpfa_pkg::OP_USE)
                begin
                    if (m_cnt != CNT_MAX)
                    begin
                        ev_meta  = {m_res, m_inl, m_cnt + CW'(1)};
                        ev_mwe   = 1'b1;
                        ev_usage = m_cnt + CW'(1);
                    end
                end
                else
                begin
                    ev_meta  = {m_res, m_inl, cnt_dec};
                    ev_mwe   = 1'b1;
                    ev_usage = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        // Last reference dropped: the frame goes back on a list.
                        ev_meta[CW] = 1'b1;
                        ev_push     = !m_inl;
                        ev_free_inc = 1'b1;
                        ev_used_dec = 1'b1;
                    end
                end
            end
            zpfa_pkg::OP_RESERVE:
            begin
                if (m_cnt != '0)
                begin
                    ev_status = zpfa_pkg::ST_REFERR;
                end
                else if (!m_res)
                begin
                    ev_meta     = {1'b1, 1'b0, m_cnt};
                    ev_mwe      = 1'b1;
                    ev_unlink   = m_inl;
                    ev_free_dec = 1'b1;
                end
            end
            default:
            begin
                ev_usage = m_cnt;
            end
        endcase
    end

    // Zone of the frame being pushed, under the limits in force now.
    logic [1:0]    push_zone;
    logic [LW-1:0] push_head;
    logic [LW-1:0] tgt_link;

    assign tgt_link = {1'b0, tgt_reg};

    always_comb
    begin
        if (32'(tgt_reg) < 32'(bios_limit_reg))
        begin
            push_zone = zpfa_pkg::ZN_BIOS;
        end
        else if (32'(tgt_reg) < 32'(dma_limit_reg))
        begin
            push_zone = zpfa_pkg::ZN_DMA;
        end
        else
        begin
            push_zone = zpfa_pkg::ZN_NORMAL;
        end
        push_head = head_reg[push_zone];
    end

    // RAM port steering.
    always_comb
    begin
        m_we    = 1'b0;
        m_waddr = tgt_reg;
        m_wdata = ev_meta;
        m_re    = (state_reg == S_RD);
        l_we    = 1'b0;
        l_waddr = tgt_reg;
        l_wdata = {push_head, NULL_LINK};
        l_re    = 1'b0;
        l_raddr = tgt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                m_wdata = {1'b1, 1'b0, {CW{1'b0}}};
            end
            S_RD:
            begin
                l_re = 1'b1;
            end
            S_EVAL:
            begin
                m_we = ev_mwe;
            end
            S_U1:
            begin
                l_re    = !p_reg[LW-1];
                l_raddr = p_reg[FB-1:0];
            end
            S_U2:
            begin
                l_we    = 1'b1;
                l_waddr = p_reg[FB-1:0];
                l_wdata = {n_reg, lq_prev};
            end
            S_U3:
            begin
                l_re    = !n_reg[LW-1];
                l_raddr = n_reg[FB-1:0];
            end
            S_U4:
            begin
                l_we    = 1'b1;
                l_waddr = n_reg[FB-1:0];
                l_wdata = {lq_next, p_reg};
            end
            S_P1:
            begin
                l_we    = 1'b1;
                l_re    = !push_head[LW-1];
                l_raddr = push_head[FB-1:0];
            end
            S_P2:
            begin
                l_we    = 1'b1;
                l_waddr = h_reg[FB-1:0];
                l_wdata = {lq_next, tgt_link};
            end
            default:
            begin
                m_we = 1'b0;
            end
        endcase
    end

    // Saturating totals after evaluation.
    logic [16:0] free_next;
    logic [16:0] used_next;

    always_comb
    begin
        free_next = free_cnt_reg;
        used_next = used_cnt_reg;
        if (ev_free_inc && free_cnt_reg != zpfa_pkg::TOT_MAX)
        begin
            free_next = free_cnt_reg + 17'd1;
        end
        else if (ev_free_dec && free_cnt_reg != '0)
        begin
            free_next = free_cnt_reg - 17'd1;
        end
        if (ev_used_inc && used_cnt_reg != zpfa_pkg::TOT_MAX)
        begin
            used_next = used_cnt_reg + 17'd1;
        end
        else if (ev_used_dec && used_cnt_reg != '0)
        begin
            used_next = used_cnt_reg - 17'd1;
        end
    end

    // Configuration registers accept a beat at any time.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frame_reg <= zpfa_pkg::LAST_FRAME_RST;
            bios_limit_reg <= zpfa_pkg::BIOS_LIMIT_RST;
            dma_limit_reg  <= zpfa_pkg::DMA_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                zpfa_pkg::CFG_LAST_FRAME: last_frame_reg <= cfg_data[15:0];
                zpfa_pkg::CFG_BIOS_LIMIT: bios_limit_reg <= cfg_data;
                zpfa_pkg::CFG_DMA_LIMIT:  dma_limit_reg  <= cfg_data;
                default:                  last_frame_reg <= last_frame_reg;
            endcase
        end
    end

    // Sequencer: state, list heads, totals and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
            free_cnt_reg <= '0;
            used_cnt_reg <= '0;
            for (int z = 0; z < 3; z++)
            begin
                head_reg[z] <= NULL_LINK;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + FB'(1);
                    if (clr_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg      <= opcode;
                        granted_reg <= '0;
                        usage_reg   <= '0;
                        if (opcode == zpfa_pkg::OP_ALLOC)
                        begin
                            tgt_reg <= head_reg[alloc_zone][FB-1:0];
                            if (alloc_fail)
                            begin
                                status_reg <= alloc_status;
                                state_reg  <= S_FIN;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                            end
                        end
                        else
                        begin
                            tgt_reg <= FB'(frame_number);
                            if (opcode > zpfa_pkg::OP_QUERY || !exists)
                            begin
                                status_reg <= zpfa_pkg::ST_IGNORED;
                                state_reg  <= S_FIN;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    status_reg   <= ev_status;
                    usage_reg    <= ev_usage;
                    granted_reg  <= (op_reg == zpfa_pkg::OP_ALLOC) ? 16'(tgt_reg) : 16'd0;
                    free_cnt_reg <= free_next;
                    used_cnt_reg <= used_next;
                    n_reg        <= lq_next;
                    p_reg        <= lq_prev;
                    push_reg     <= ev_push;
                    unlink_reg   <= ev_unlink;
                    if (ev_unlink)
                    begin
                        state_reg <= S_U1;
                    end
                    else if (ev_push)
                    begin
                        state_reg <= S_P1;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_U1:
                begin
                    // A frame with no predecessor is a list head.
                    if (p_reg[LW-1])
                    begin
                        for (int z = 0; z < 3; z++)
                        begin
                            if (head_reg[z] == tgt_link)
                            begin
                                head_reg[z] <= n_reg;
                            end
                        end
                        state_reg <= S_U3;
                    end
                    else
                    begin
                        state_reg <= S_U2;
                    end
                end
                S_U2:
                begin
                    state_reg <= S_U3;
                end
                S_U3:
                begin
                    state_reg <= n_reg[LW-1] ? S_FIN : S_U4;
                end
                S_U4:
                begin
                    state_reg <= S_FIN;
                end
                S_P1:
                begin
                    head_reg[push_zone] <= tgt_link;
                    h_reg               <= push_head;
                    state_reg           <= push_head[LW-1] ? S_FIN : S_P2;
                end
                S_P2:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_frame = granted_reg;
    assign usage_count   = 16'(usage_reg);
    assign free_total    = free_cnt_reg;
    assign used_total    = used_cnt_reg;

    // A result beat only ever closes an operation that was in flight.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without an operation in flight");

    // A failed or rejected operation never hands out a frame.
    a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != zpfa_pkg::ST_OK) |-> (granted_frame == 16'd0))
        else $error("frame granted on a failed operation");

    // Push and unlink never run for the same operation.
    a_push_xor_unlink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_U1 || state_reg == S_P1) |-> !(push_reg && unlink_reg))
        else $error("push and unlink requested together");

endmodule
